@@ hw/rtl/gdt_pkg.sv @@
// gdt_pkg: shared types, register codes and tables for the gray dither block.
// No dependencies; imported by every module under hw/rtl.
package gdt_pkg;

  // Row scaling divider: quotient bits and step counter width
  localparam int DIV_W = 23;
  localparam int CNT_W = $clog2(DIV_W);

  // Configuration register indexes
  localparam logic [2:0] CFG_FB_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_FB_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] CFG_DEST_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_SRC_HEIGHT  = 3'd5;
  localparam logic [2:0] CFG_DITHER_MODE = 3'd6;
  localparam logic [2:0] CFG_COLOR_MODE  = 3'd7;

  // Dither modes (code 3 falls back to threshold)
  localparam logic [1:0] DITHER_THRESH = 2'd0;
  localparam logic [1:0] DITHER_BAYER  = 2'd1;
  localparam logic [1:0] DITHER_CARRY  = 2'd2;

  // Color modes (codes 6 and 7 give mid gray)
  localparam logic [2:0] COLOR_GRAY1 = 3'd0;
  localparam logic [2:0] COLOR_GRAY2 = 3'd1;
  localparam logic [2:0] COLOR_GRAY4 = 3'd2;
  localparam logic [2:0] COLOR_GRAY8 = 3'd3;
  localparam logic [2:0] COLOR_RGB   = 3'd4;
  localparam logic [2:0] COLOR_RGBA  = 3'd5;

  localparam logic [7:0] GRAY_MID   = 8'd128;
  localparam logic [7:0] THRESH_LVL = 8'd127;

  // 8x8 Bayer matrix, indexed by {row[2:0], col[2:0]}
  localparam logic [5:0] BAYER [0:63] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  typedef struct packed {
    logic [10:0] dest_col;
    logic [10:0] src_row;
    logic [7:0]  sample_a;
    logic [7:0]  sample_b;
    logic [7:0]  sample_c;
    logic [7:0]  alpha;
  } in_word_t;

  typedef struct packed {
    logic [18:0] byte_index;
    logic [7:0]  bit_mask;
    logic        pixel_white;
  } out_word_t;

  typedef struct packed {
    logic [11:0] fb_width;
    logic [11:0] fb_height;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [11:0] dest_height;
    logic [11:0] src_height;
    logic [1:0]  dither_mode;
    logic [2:0]  color_mode;
  } cfg_regs_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture input word
    logic prep;      // products, column position, divider setup
    logic div_step;  // one restoring division step
    logic gray;      // gray level, row position, bounds
    logic emit;      // dither decision, address, output load
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scale_en;  // row scaling active
    logic out_free;  // output register can take a word this cycle
  } dp_sts_t;

endpackage

@@ hw/rtl/gdt_cfg.sv @@
// gdt_cfg: configuration register file, written one register per handshake.
// Depends on gdt_pkg.
module gdt_cfg import gdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [11:0] wr_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_FB_WIDTH:    regs_nxt.fb_width    = wr_data;
        CFG_FB_HEIGHT:   regs_nxt.fb_height   = wr_data;
        CFG_ORIGIN_X:    regs_nxt.origin_x    = wr_data;
        CFG_ORIGIN_Y:    regs_nxt.origin_y    = wr_data;
        CFG_DEST_HEIGHT: regs_nxt.dest_height = wr_data;
        CFG_SRC_HEIGHT:  regs_nxt.src_height  = wr_data;
        CFG_DITHER_MODE: regs_nxt.dither_mode = wr_data[1:0];
        CFG_COLOR_MODE:  regs_nxt.color_mode  = wr_data[2:0];
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.fb_width    <= 12'd800;
      regs_r.fb_height   <= 12'd480;
      regs_r.origin_x    <= 12'd0;
      regs_r.origin_y    <= 12'd0;
      regs_r.dest_height <= 12'd0;
      regs_r.src_height  <= 12'd0;
      regs_r.dither_mode <= DITHER_THRESH;
      regs_r.color_mode  <= COLOR_GRAY8;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

@@ hw/rtl/gdt_ctrl.sv @@
// gdt_ctrl: sequencer for one pixel word: load, prep, divide, gray, emit.
// Depends on gdt_pkg; drives gdt_dp through dp_cmd_t.
module gdt_ctrl import gdt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_GRAY = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.scale_en ? ST_DIV : ST_GRAY;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_GRAY;
        end
      end
      ST_GRAY: begin
        cmd.gray  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/gdt_dp.sv @@
// gdt_dp: pixel datapath: blend products, bit-serial row divider, gray,
// bounds, dither, address and output register. Depends on gdt_pkg.
module gdt_dp import gdt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  in_word_t          in_r;
  logic [15:0]       prod_r [3];
  logic [15:0]       prod_nxt [3];
  logic [12:0]       ax_r, ax_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [11:0]       rem_r, rem_nxt;
  logic [7:0]        gray_r, gray_nxt;
  logic [11:0]       ay_r;
  logic              onscreen_r, onscreen_nxt;
  logic signed [6:0] carry_r, carry_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [7:0]  chan_raw [3];
  logic [7:0]  chan_sel [3];
  logic [16:0] ow_x1 [3];
  logic [16:0] ow_s [3];
  logic [15:0] luma_sum;
  logic [24:0] ay_full;
  logic [13:0] div_sub;
  logic [DIV_W-1:0] dividend;
  logic [20:0] addr_full;

  logic [9:0]  dv_val;
  logic [7:0]  dv_clamp;
  logic        dv_white;
  logic [8:0]  dv_err;
  logic [6:0]  dv_mag;
  logic [9:0]  dv_mag7;
  logic [6:0]  carry_in;
  logic [7:0]  bayer_th;
  logic        white;

  assign sts.scale_en = (cfg.dest_height != cfg.src_height) &&
                        (cfg.dest_height != 12'd0) && (cfg.src_height != 12'd0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign chan_raw[0] = in_r.sample_a;
  assign chan_raw[1] = in_r.sample_b;
  assign chan_raw[2] = in_r.sample_c;

  // prep: over-white blend numerators, column position, divider setup
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = {8'd0, chan_raw[i]} * {8'd0, in_r.alpha}
                  + {8'd0, 8'd255 - in_r.alpha} * 16'd255;
    end
  end

  assign ax_nxt   = {cfg.origin_x[11], cfg.origin_x} + {2'b00, in_r.dest_col};
  assign dividend = {12'd0, in_r.src_row} * {11'd0, cfg.dest_height};

  // restoring division step, remainder stays below the divisor
  assign div_sub = {1'b0, rem_r, q_r[DIV_W-1]} - {2'b00, cfg.src_height};

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (cmd.prep) begin
      q_nxt   = sts.scale_en ? dividend : {12'd0, in_r.src_row};
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      if (!div_sub[13]) begin
        rem_nxt = div_sub[11:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[10:0], q_r[DIV_W-1]};
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  // gray: x/255 as (x+1 + ((x+1)>>8)) >> 8, exact below 2^16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ow_x1[i] = {1'b0, prod_r[i]} + 17'd1;
      ow_s[i]  = ow_x1[i] + (ow_x1[i] >> 8);
      chan_sel[i] = (cfg.color_mode == COLOR_RGBA) ? ow_s[i][15:8] : chan_raw[i];
    end
    luma_sum = {8'd0, chan_sel[0]} * 16'd77 + {8'd0, chan_sel[1]} * 16'd150
             + {8'd0, chan_sel[2]} * 16'd29;
  end

  always_comb begin
    case (cfg.color_mode) inside
      COLOR_GRAY1: gray_nxt = {8{in_r.sample_a[0]}};
      COLOR_GRAY2: gray_nxt = {6'd0, in_r.sample_a[1:0]} * 8'd85;
      COLOR_GRAY4: gray_nxt = {in_r.sample_a[3:0], in_r.sample_a[3:0]};
      COLOR_GRAY8: gray_nxt = in_r.sample_a;
      COLOR_RGB, COLOR_RGBA: gray_nxt = luma_sum[15:8];
      default:     gray_nxt = GRAY_MID;
    endcase
  end

  assign ay_full = {{13{cfg.origin_y[11]}}, cfg.origin_y} + {2'b00, q_r};
  assign onscreen_nxt = !ay_full[24] && (ay_full < {13'd0, cfg.fb_height}) &&
                        !ax_r[12] && (ax_r < {1'b0, cfg.fb_width});

  // emit: dither decision and carry
  assign carry_in = (in_r.dest_col == 11'd0) ? 7'd0 : carry_r;
  assign dv_val   = {2'b00, gray_r} + {{3{carry_in[6]}}, carry_in};
  assign dv_clamp = dv_val[9] ? 8'd0 : (dv_val[8] ? 8'd255 : dv_val[7:0]);
  assign dv_white = dv_clamp[7];
  assign dv_err   = dv_white ? ({1'b0, dv_clamp} - 9'd255) : {1'b0, dv_clamp};
  assign dv_mag   = dv_err[8] ? 7'(9'd0 - dv_err) : dv_err[6:0];
  assign dv_mag7  = {3'd0, dv_mag} * 10'd7;
  assign bayer_th = {BAYER[{ay_r[2:0], ax_r[2:0]}], 2'b00};

  always_comb begin
    carry_nxt = '0;
    case (cfg.dither_mode)
      DITHER_BAYER: white = gray_r > bayer_th;
      DITHER_CARRY: begin
        white     = dv_white;
        carry_nxt = dv_err[8] ? 7'(7'd0 - {1'b0, dv_mag7[9:4]})
                              : {1'b0, dv_mag7[9:4]};
      end
      default:      white = gray_r > THRESH_LVL;
    endcase
  end

  assign addr_full = {9'd0, ay_r} * {12'd0, cfg.fb_width[11:3]}
                   + {12'd0, ax_r[11:3]};

  always_comb begin
    out_nxt.byte_index  = addr_full[18:0];
    out_nxt.bit_mask    = 8'h80 >> ax_r[2:0];
    out_nxt.pixel_white = white;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit && onscreen_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.prep) begin
      prod_r <= prod_nxt;
      ax_r   <= ax_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (cmd.gray) begin
      gray_r     <= gray_nxt;
      ay_r       <= ay_full[11:0];
      onscreen_r <= onscreen_nxt;
    end
    if (cmd.emit && onscreen_r) begin
      out_r <= out_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      carry_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.emit) begin
        carry_r <= onscreen_r ? carry_nxt : 7'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/pixel_gray_dither_to_1bpp.sv @@
// pixel_gray_dither_to_1bpp: top level, gray conversion and 1 bpp dither.
// Depends on gdt_pkg, gdt_cfg, gdt_ctrl and gdt_dp.
//
//   channel | handshake            | word
//   --------+----------------------+--------------------------------------
//   in_     | in_valid / in_stall  | in_word_t: column, source row, samples
//   out_    | out_valid / out_stall| out_word_t: byte index, mask, white
//   cfg_    | cfg_valid / cfg_ready| cfg_index (3 b), cfg_data (12 b)
//
// One word at a time: without row scaling a word goes load, prep, gray, emit;
// with it the bit-serial restoring divider (one quotient bit per cycle) that
// maps the source row to the destination row runs between prep and gray.
// An off-screen word goes through the same steps and produces nothing.
// The finished word sits in an output register, so the next input word
// is taken while it waits; a held out_stall only blocks the emit step.
// Reset (rst_n low, synchronous) loads register defaults and clears the
// error carry; cfg_ready is always high.
module pixel_gray_dither_to_1bpp import gdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_regs_t cfg;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  // register file
  gdt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  // sequencer
  gdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // gray, divider, bounds, dither, address, output register
  gdt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
